### hw/rtl/qfpr_pkg.sv
// Package for the period reciprocal block: widths, register indexes and pipeline stage type.
`timescale 1ns / 1ps
package qfpr_pkg;

  localparam int TIME_W = 32;
  localparam int FMT_W  = 5;
  localparam int FREQ_W = 16;
  localparam int NCELLS = 16;
  localparam int IDX_W  = 1;

  localparam logic [FMT_W-1:0] Q_SPLIT     = 5'd15;
  localparam logic [FMT_W-1:0] Q_FMT_RESET = 5'd15;

  localparam logic [IDX_W-1:0] REG_CALIB_OFFSET = 1'b0;
  localparam logic [IDX_W-1:0] REG_Q_FORMAT     = 1'b1;

  // one item in flight between two cells
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [TIME_W-1:0] divisor;
    logic [TIME_W-1:0] rem;
    logic [NCELLS-1:0] dvd;
    logic [FREQ_W-1:0] quot;
  } qfpr_stage_t;

endpackage

### hw/rtl/qfpr_if.sv
// Handshake channels for time counts in and frequency results out.
`timescale 1ns / 1ps
interface qfpr_in_if;
  import qfpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_count;
  modport source (output valid, output time_count, input ready);
  modport sink   (input valid, input time_count, output ready);
endinterface

interface qfpr_out_if;
  import qfpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic              zero_divisor;
  modport source (output valid, output frequency, output zero_divisor, input ready);
  modport sink   (input valid, input frequency, input zero_divisor, output ready);
endinterface

### hw/rtl/qfpr_prep.sv
// Front stage: offset correction, format shift and dividend setup.
`timescale 1ns / 1ps
module qfpr_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [qfpr_pkg::TIME_W-1:0] time_count,
  input  logic [qfpr_pkg::TIME_W-1:0] calib_offset,
  input  logic [qfpr_pkg::FMT_W-1:0]  q_format,
  output qfpr_pkg::qfpr_stage_t       stage_q
);
  import qfpr_pkg::*;

  logic [TIME_W-1:0] diff;
  logic [FMT_W-1:0]  tshift;
  qfpr_stage_t       stage_next;

  always_comb begin
    diff = time_count - calib_offset;
    stage_next = '0;
    stage_next.valid = in_valid;
    if (q_format > Q_SPLIT) begin
      tshift = q_format - Q_SPLIT;
      // dividend is 2^31: top dividend bit
      stage_next.dvd = {1'b1, {(NCELLS-1){1'b0}}};
    end else begin
      tshift = '0;
      stage_next.dvd = NCELLS'(1) << q_format[3:0];
    end
    stage_next.divisor = diff >> tshift;
    stage_next.zero    = (stage_next.divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_q.valid <= 1'b0;
    end else if (adv) begin
      stage_q.valid <= stage_next.valid;
    end
    if (adv) begin
      stage_q.zero    <= stage_next.zero;
      stage_q.divisor <= stage_next.divisor;
      stage_q.rem     <= stage_next.rem;
      stage_q.dvd     <= stage_next.dvd;
      stage_q.quot    <= stage_next.quot;
    end
  end

endmodule

### hw/rtl/qfpr_cell.sv
// Divider cell: one restoring step, produces one quotient bit.
`timescale 1ns / 1ps
module qfpr_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  qfpr_pkg::qfpr_stage_t stage_d,
  output qfpr_pkg::qfpr_stage_t stage_q
);
  import qfpr_pkg::*;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   dext;
  logic [TIME_W:0]   sub;
  logic              ge;
  logic [TIME_W-1:0] rem_next;

  always_comb begin
    // bring down the next dividend bit
    trial    = {stage_d.rem, stage_d.dvd[NCELLS-1]};
    dext     = {1'b0, stage_d.divisor};
    ge       = (trial >= dext);
    sub      = trial - dext;
    rem_next = ge ? sub[TIME_W-1:0] : trial[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_q.valid <= 1'b0;
    end else if (adv) begin
      stage_q.valid <= stage_d.valid;
    end
    if (adv) begin
      stage_q.zero    <= stage_d.zero;
      stage_q.divisor <= stage_d.divisor;
      stage_q.rem     <= rem_next;
      stage_q.dvd     <= {stage_d.dvd[NCELLS-2:0], 1'b0};
      stage_q.quot    <= {stage_d.quot[FREQ_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/q_format_period_reciprocal.sv
// Top level: period count to Q-format frequency through a pipelined divider chain.
//
//  channel   dir   fields                      handshake
//  sample    in    time_count[31:0]            valid/ready
//  result    out   frequency[15:0], zero_div   valid/ready
//  cfg       in    cfg_index, cfg_wdata[31:0]  cfg_we, no back-pressure
//
// One item per cycle while the chain does not hold: one front stage for offset and
// shift, then sixteen divider cells, one quotient bit each (bits 31..16).
// The last cell register is the output register. The whole chain holds
// while a result waits and result.ready is low.
// Synchronous reset empties the chain and loads calib_offset 0, q_format 15.
`timescale 1ns / 1ps
module q_format_period_reciprocal (
  input  logic                          clk,
  input  logic                          rst,
  qfpr_in_if.sink                       sample,
  qfpr_out_if.source                    result,
  input  logic                          cfg_we,
  input  logic [qfpr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qfpr_pkg::TIME_W-1:0]   cfg_wdata
);
  import qfpr_pkg::*;

  logic [TIME_W-1:0] calib_offset;
  logic [FMT_W-1:0]  q_format;
  logic              adv;
  qfpr_stage_t       st [NCELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_offset <= '0;
      q_format     <= Q_FMT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALIB_OFFSET: calib_offset <= cfg_wdata;
        REG_Q_FORMAT:     q_format     <= cfg_wdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the chain unless the finished item is still waiting
  assign adv          = !st[NCELLS].valid || result.ready;
  assign sample.ready = adv;

  qfpr_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (sample.valid),
    .time_count   (sample.time_count),
    .calib_offset (calib_offset),
    .q_format     (q_format),
    .stage_q      (st[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    qfpr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .stage_d (st[i]),
      .stage_q (st[i+1])
    );
  end

  assign result.valid        = st[NCELLS].valid;
  assign result.zero_divisor = st[NCELLS].zero;
  assign result.frequency    = st[NCELLS].zero ? '0 : st[NCELLS].quot;

endmodule

### sim/testbench.sv
// Testbench for q_format_period_reciprocal: random and directed time counts checked by a scoreboard.
`timescale 1ns / 1ps
module testbench;
  import qfpr_pkg::*;

  localparam int Q_BASE       = 16;
  localparam int IDLE_PERCENT = 18;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              zero_divisor;
  } freq_result_t;

  class freq_scoreboard;
    freq_result_t expected_freqs[$];
    int           errors = 0;

    function freq_result_t predict_frequency(logic [TIME_W-1:0] t, logic [TIME_W-1:0] offset,
                                             logic [FMT_W-1:0] fmt);
      freq_result_t      r;
      logic [TIME_W-1:0] divisor;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W-1:0] quot;
      divisor = t - offset;
      if (fmt > Q_SPLIT) begin
        divisor  = divisor >> (fmt - Q_SPLIT);
        dividend = 32'h8000_0000;
      end else begin
        dividend = 32'd1 << (int'(fmt) + Q_BASE);
      end
      if (divisor == '0) begin
        r.frequency    = '0;
        r.zero_divisor = 1'b1;
      end else begin
        quot           = dividend / divisor;
        r.frequency    = quot[31:16];
        r.zero_divisor = 1'b0;
      end
      return r;
    endfunction

    function void note_time(logic [TIME_W-1:0] t, logic [TIME_W-1:0] offset,
                            logic [FMT_W-1:0] fmt);
      expected_freqs.push_back(predict_frequency(t, offset, fmt));
    endfunction

    function void check_result(logic [FREQ_W-1:0] freq, logic zero);
      freq_result_t want;
      if (expected_freqs.size() == 0) begin
        $error("unexpected result: frequency=%0h zero_divisor=%0b", freq, zero);
        errors++;
        return;
      end
      want = expected_freqs.pop_front();
      if (freq !== want.frequency) begin
        $error("frequency: expected %0h, actual %0h", want.frequency, freq);
        errors++;
      end
      if (zero !== want.zero_divisor) begin
        $error("zero_divisor: expected %0b, actual %0b", want.zero_divisor, zero);
        errors++;
      end
    endfunction

    function int pending();
      return expected_freqs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [TIME_W-1:0] cfg_wdata;

  qfpr_in_if  sample_ch ();
  qfpr_out_if result_ch ();

  q_format_period_reciprocal DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  freq_scoreboard    sb = new();
  logic [TIME_W-1:0] calib_mirror = '0;
  logic [FMT_W-1:0]  fmt_mirror   = Q_FMT_RESET;
  bit                idle_on      = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        sb.note_time(sample_ch.time_count, calib_mirror, fmt_mirror);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.frequency, result_ch.zero_divisor);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_CALIB_OFFSET)
      calib_mirror = data;
    else
      fmt_mirror = data[FMT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits are junk on purpose: the format register keeps only its low bits
  task automatic write_format(logic [FMT_W-1:0] fmt);
    logic [TIME_W-1:0] data;
    data = $urandom;
    data[FMT_W-1:0] = fmt;
    write_reg(REG_Q_FORMAT, data);
  endtask

  task automatic send_time(logic [TIME_W-1:0] t);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.time_count <= t;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // bias toward corrected times of every magnitude, zero included
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] span;
    int unsigned       k;
    int unsigned       tsh;
    tsh = (fmt_mirror > Q_SPLIT) ? int'(fmt_mirror - Q_SPLIT) : 0;
    if ($urandom_range(3) == 0)
      return $urandom;
    k = $urandom_range(32);
    span = (k == 32) ? $urandom : ($urandom & ((32'd1 << k) - 1));
    return calib_mirror + (span << tsh) + ($urandom & ((32'd1 << tsh) - 1));
  endfunction

  initial begin
    logic [TIME_W-1:0] offsets[NUM_PHASES];
    logic [FMT_W-1:0]  formats[NUM_PHASES];
    offsets = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1000, $urandom, $urandom, 32'd0, $urandom};
    formats = '{5'd0, 5'd31, 5'd16, 5'd15, 5'd1, 5'd30, FMT_W'($urandom), FMT_W'($urandom)};

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_CALIB_OFFSET;
    cfg_wdata            = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.time_count = '0;
    result_ch.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: no offset, format 15
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'd2);
    send_time(32'h0000_FFFF);
    send_time(32'h0000_8000);
    send_time(32'h0001_0000);
    send_time(32'h7FFF_FFFF);
    send_time(32'h8000_0000);
    send_time(32'hFFFF_FFFF);
    drain_results();

    // widest format: shifted divisor, wraparound below the offset
    write_reg(REG_CALIB_OFFSET, 32'd100);
    write_reg(REG_Q_FORMAT, 32'hFFFF_FFFF);
    send_time(32'd100);
    send_time(32'd99);
    send_time(32'd100 + 32'h0001_0000);
    send_time(32'd100 + 32'h0000_FFFF);
    send_time(32'd100 + 32'h0002_0000);
    drain_results();

    write_reg(REG_CALIB_OFFSET, 32'hFFFF_FFFF);
    write_format(5'd0);
    send_time(32'hFFFF_FFFF);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'hFFFF_FFFE);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_CALIB_OFFSET, offsets[p]);
      write_format(formats[p]);
      idle_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_time(pick_time());
      drain_results();
    end
    idle_on = 1'b1;

    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("q_format_period_reciprocal: match");
    else
      $display("q_format_period_reciprocal: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("q_format_period_reciprocal: mismatch");
    $finish;
  end

endmodule
